[rtl/neighbor_sign_descriptor_macros.svh]
// Assertion macros for the checker file.
// Each expects clk and rst to be visible where it is used.
`ifndef NEIGHBOR_SIGN_DESCRIPTOR_MACROS_SVH
`define NEIGHBOR_SIGN_DESCRIPTOR_MACROS_SVH

// Consequent checked at the same edge as the antecedent.
`define NSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the edge after the antecedent.
`define NSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nsd_pkg.sv]
`default_nettype none

package nsd_pkg;

  localparam int PIXEL_W   = 8;
  localparam int INDEX_W   = 12;
  localparam int HS_W      = 7;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HASH_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd1;

  // Operating modes
  localparam logic [MODE_W-1:0] MODE_EIGHT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HORIZ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VERT   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [HS_W-1:0] HASH_SIZE_RESET = 7'd8;

  // One accepted pixel with its frame bookkeeping
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [MODE_W-1:0]  mode;
    logic               emit;
    logic               last;
    logic [INDEX_W-1:0] index;
  } nsd_item_t;

  // One descriptor element
  typedef struct packed {
    logic [PIXEL_W-1:0] sign_bits;
    logic [INDEX_W-1:0] element_index;
    logic               last;
  } nsd_result_t;

endpackage

`default_nettype wire

[rtl/nsd_intf.sv]
`default_nettype none

interface nsd_pixel_if import nsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface nsd_result_if import nsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] sign_bits;
  logic [INDEX_W-1:0] element_index;
  logic               last;
  modport source (output valid, output sign_bits, output element_index, output last,
                  input ready);
  modport sink (input valid, input sign_bits, input element_index, input last,
                output ready);
endinterface

interface nsd_cfg_if import nsd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [HS_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/neighbor_sign_descriptor.sv]
`default_nettype none
// Channel  | Role   | Payload
// ---------+--------+--------------------------------------------
// cfg      | sink   | index (0 hash_size, 1 mode), data [6:0]
// pixels   | sink   | pixel [7:0], raster order
// results  | source | sign_bits [7:0], element_index [11:0], last
//
// One pixel per cycle sustained while results are taken; a pixel's line entry is
// read at acceptance and written back from the hold stage, with forwarding between
// neighbors, and its element is then presented from the output register.
// Reset (rst, synchronous) restores hash_size 8, mode 0 and a fresh frame.
// A stalled results channel holds the output register and, once an element
// is due behind it, backs up into pixels.ready. cfg is always ready.

module neighbor_sign_descriptor import nsd_pkg::*; #(
  parameter int MAX_HASH_SIZE = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  nsd_cfg_if.sink       cfg,
  nsd_pixel_if.sink     pixels,
  nsd_result_if.source  results
);

  localparam int DEPTH = MAX_HASH_SIZE + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_HASH_SIZE + 3);

  logic                 accept;
  logic                 in_ready;
  nsd_item_t            item;
  logic [AW-1:0]        raddr;
  logic [2*PIXEL_W-1:0] rdata;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [2*PIXEL_W-1:0] wdata;
  nsd_result_t          res;

  assign cfg.ready    = 1'b1;
  assign pixels.ready = in_ready;
  assign accept       = pixels.valid && in_ready;

  nsd_front #(
    .MAX_HASH_SIZE (MAX_HASH_SIZE),
    .NW            (NW),
    .AW            (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .accept    (accept),
    .pixel     (pixels.pixel),
    .item      (item),
    .addr      (raddr)
  );

  // Both line stores share one entry per column: {older, previous}
  nsd_ram #(
    .WIDTH (2 * PIXEL_W),
    .DEPTH (DEPTH)
  ) u_lines (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  nsd_window #(
    .AW (AW)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixels.valid),
    .in_ready  (in_ready),
    .item_in   (item),
    .addr_in   (raddr),
    .rdata     (rdata),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res       (res)
  );

  assign results.sign_bits     = res.sign_bits;
  assign results.element_index = res.element_index;
  assign results.last          = res.last;

endmodule

`default_nettype wire

[rtl/nsd_ram.sv]
`default_nettype none

module nsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 66
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/nsd_front.sv]
`default_nettype none

module nsd_front import nsd_pkg::*; #(
  parameter int MAX_HASH_SIZE = 64,
  parameter int NW = 7,
  parameter int AW = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [HS_W-1:0]      cfg_data,
  input  wire logic                 accept,
  input  wire logic [PIXEL_W-1:0]   pixel,
  output nsd_item_t                 item,
  output logic      [AW-1:0]        addr
);

  logic [HS_W-1:0]    hash_size;
  logic [MODE_W-1:0]  mode;
  logic [NW-1:0]      col;
  logic [NW-1:0]      row;
  logic [INDEX_W-1:0] element_count;

  logic [NW-1:0]     n;
  logic [NW-1:0]     w;
  logic [NW-1:0]     h;
  logic [MODE_W-1:0] m;
  logic              emit;
  logic              frame_end;

  // Clamp the side length into its legal range
  always_comb begin
    if (hash_size == '0) begin
      n = NW'(1);
    end else if (32'(hash_size) > 32'(MAX_HASH_SIZE)) begin
      n = NW'(MAX_HASH_SIZE);
    end else begin
      n = NW'(hash_size);
    end
  end

  // Grid shape and emit condition per mode
  always_comb begin
    m = (mode == MODE_UNUSED) ? MODE_EIGHT : mode;
    case (m)
      MODE_HORIZ: begin
        w    = n + NW'(1);
        h    = n;
        emit = (col >= NW'(1));
      end
      MODE_VERT: begin
        w    = n;
        h    = n + NW'(1);
        emit = (row >= NW'(1));
      end
      default: begin
        w    = n + NW'(2);
        h    = n + NW'(2);
        emit = (row >= NW'(2)) && (col >= NW'(2));
      end
    endcase
    frame_end = (row == h - NW'(1)) && (col == w - NW'(1));
  end

  assign item.pixel = pixel;
  assign item.mode  = m;
  assign item.emit  = emit;
  assign item.last  = frame_end;
  assign item.index = element_count;
  assign addr       = col[AW-1:0];

  // Hold registers; restart the frame on a write to either register; advance on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_size     <= HASH_SIZE_RESET;
      mode          <= MODE_EIGHT;
      col           <= '0;
      row           <= '0;
      element_count <= '0;
    end else if (cfg_we && (cfg_index == REG_HASH_SIZE || cfg_index == REG_MODE)) begin
      if (cfg_index == REG_HASH_SIZE) begin
        hash_size <= cfg_data;
      end else begin
        mode <= cfg_data[MODE_W-1:0];
      end
      col           <= '0;
      row           <= '0;
      element_count <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col           <= '0;
        row           <= '0;
        element_count <= '0;
      end else begin
        if (emit) begin
          element_count <= element_count + INDEX_W'(1);
        end
        if (col == w - NW'(1)) begin
          col <= '0;
          row <= row + NW'(1);
        end else begin
          col <= col + NW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/nsd_window.sv]
`default_nettype none

module nsd_window import nsd_pkg::*; #(
  parameter int AW = 7
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire nsd_item_t              item_in,
  input  wire logic      [AW-1:0]     addr_in,
  input  wire logic      [2*PIXEL_W-1:0] rdata,
  output logic                        we,
  output logic           [AW-1:0]     waddr,
  output logic           [2*PIXEL_W-1:0] wdata,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output nsd_result_t                 res
);

  logic                   s1_valid;
  nsd_item_t              s1_item;
  logic [AW-1:0]          s1_addr;
  logic                   fwd_valid;
  logic [AW-1:0]          fwd_addr;
  logic [2*PIXEL_W-1:0]   fwd_data;
  logic [PIXEL_W-1:0]     win_mid [3];
  logic [PIXEL_W-1:0]     win_right [3];

  logic                   s1_adv;
  logic [2*PIXEL_W-1:0]   line;
  logic [PIXEL_W-1:0]     older_rd;
  logic [PIXEL_W-1:0]     prev_rd;
  logic [PIXEL_W-1:0]     ctr;
  logic [PIXEL_W-1:0]     bits;

  // Advance when the output register can take the element or none is due
  assign s1_adv   = s1_valid && (!s1_item.emit || !res_valid || res_ready);
  assign in_ready = !s1_valid || s1_adv;

  // Forward the last write when it hits the entry just read
  assign line     = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rdata;
  assign older_rd = line[2*PIXEL_W-1:PIXEL_W];
  assign prev_rd  = line[PIXEL_W-1:0];
  assign ctr      = win_right[1];

  // Write back the shifted column
  assign we    = s1_adv;
  assign waddr = s1_addr;
  assign wdata = {prev_rd, s1_item.pixel};

  // Compare against the shifted window
  always_comb begin
    bits = '0;
    case (s1_item.mode)
      MODE_HORIZ: begin
        bits[0] = win_right[2] > s1_item.pixel;
      end
      MODE_VERT: begin
        bits[0] = prev_rd > s1_item.pixel;
      end
      default: begin
        bits[0] = ctr > prev_rd;
        bits[1] = ctr > win_mid[1];
        bits[2] = ctr > win_right[2];
        bits[3] = ctr > win_right[0];
        bits[4] = ctr > s1_item.pixel;
        bits[5] = ctr > older_rd;
        bits[6] = ctr > win_mid[2];
        bits[7] = ctr > win_mid[0];
      end
    endcase
  end

  // Hold the pixel in flight while its line entry is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= item_in;
      s1_addr <= addr_in;
    end
  end

  // Track the most recent line write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_adv) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      fwd_addr     <= s1_addr;
      fwd_data     <= wdata;
      win_mid[0]   <= win_right[0];
      win_mid[1]   <= win_right[1];
      win_mid[2]   <= win_right[2];
      win_right[0] <= older_rd;
      win_right[1] <= prev_rd;
      win_right[2] <= s1_item.pixel;
    end
  end

  // Output register: load on a due element, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1_item.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_item.emit) begin
      res.sign_bits     <= bits;
      res.element_index <= s1_item.index;
      res.last          <= s1_item.last;
    end
  end

endmodule

`default_nettype wire

[rtl/nsd_checker.sv]
`default_nettype none
`include "neighbor_sign_descriptor_macros.svh"

module nsd_checker import nsd_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire logic [PIXEL_W-1:0] res_sign_bits,
  input wire logic [INDEX_W-1:0] res_index,
  input wire logic               res_last
);

  logic               res_acc;
  logic               cfg_acc;
  logic               clean;
  logic               prev_last;
  logic [INDEX_W-1:0] prev_index;

  assign res_acc = res_valid && res_ready;
  assign cfg_acc = cfg_valid && cfg_ready;

  // Remember the previous transaction unless a register write intervened
  always_ff @(posedge clk) begin
    if (rst) begin
      clean      <= 1'b0;
      prev_last  <= 1'b0;
      prev_index <= '0;
    end else begin
      if (res_acc) begin
        prev_last  <= res_last;
        prev_index <= res_index;
      end
      if (cfg_acc) begin
        clean <= 1'b0;
      end else if (res_acc) begin
        clean <= 1'b1;
      end
    end
  end

  `NSD_ASSERT_NEXT(a_valid_held, res_valid && !res_ready, res_valid, "result dropped while stalled")
  `NSD_ASSERT_NEXT(a_payload_held, res_valid && !res_ready, $stable(res_sign_bits) && $stable(res_index) && $stable(res_last), "result changed while stalled")
  `NSD_ASSERT_SAME(a_index_step, res_acc && clean && !prev_last, res_index == prev_index + INDEX_W'(1), "element index skipped")
  `NSD_ASSERT_SAME(a_index_restart, res_acc && clean && prev_last, res_index == '0, "frame did not restart at zero")

endmodule

bind neighbor_sign_descriptor nsd_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_valid     (cfg.valid),
  .cfg_ready     (cfg.ready),
  .res_valid     (results.valid),
  .res_ready     (results.ready),
  .res_sign_bits (results.sign_bits),
  .res_index     (results.element_index),
  .res_last      (results.last)
);

`default_nettype wire

[tb/nsd_checker.sv]
`timescale 1ns / 1ps

module nsd_scoreboard import nsd_pkg::*; #(
  parameter int MAX_HASH_SIZE = 64
) (
  input  logic  clk,
  input  logic  rst,
  nsd_cfg_if    cfg_mon,
  nsd_pixel_if  pix_mon,
  nsd_result_if res_mon,
  output int    fail_count,
  output int    pending
);

  localparam int LINE_DEPTH = MAX_HASH_SIZE + 2;

  // Predictor copy of the registers and the neighborhood stores
  logic [HS_W-1:0]    side_reg;
  logic [MODE_W-1:0]  mode_reg;
  logic [PIXEL_W-1:0] older_line [LINE_DEPTH];
  logic [PIXEL_W-1:0] prev_line  [LINE_DEPTH];
  logic [PIXEL_W-1:0] win [3][3];
  int                 row_cnt;
  int                 col_cnt;
  logic [INDEX_W-1:0] elem_cnt;

  // Descriptor elements still owed by the block, oldest first
  nsd_result_t sign_q [$];

  task automatic rewind_frame();
    row_cnt  = 0;
    col_cnt  = 0;
    elem_cnt = '0;
  endtask

  task automatic report(input string what, input int want, input int got);
    fail_count++;
    $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
  endtask

  // Shift the window by one pixel and queue the element it completes, if any
  task automatic predict_signs(input logic [PIXEL_W-1:0] pix);
    int                 n;
    int                 w;
    int                 h;
    int                 c;
    int                 r;
    logic [MODE_W-1:0]  m;
    logic               emit;
    logic               frame_end;
    logic [PIXEL_W-1:0] ctr;
    nsd_result_t        elem;
    n = int'(side_reg);
    if (n < 1) n = 1;
    if (n > MAX_HASH_SIZE) n = MAX_HASH_SIZE;
    m = (mode_reg == MODE_UNUSED) ? MODE_EIGHT : mode_reg;
    case (m)
      MODE_EIGHT: begin
        w = n + 2;
        h = n + 2;
      end
      MODE_HORIZ: begin
        w = n + 1;
        h = n;
      end
      default: begin
        w = n;
        h = n + 1;
      end
    endcase
    c = (col_cnt >= w) ? w - 1 : col_cnt;
    r = (row_cnt >= h) ? h - 1 : row_cnt;

    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = older_line[c];
    win[1][2] = prev_line[c];
    win[2][2] = pix;
    older_line[c] = prev_line[c];
    prev_line[c]  = pix;

    elem = '0;
    case (m)
      MODE_EIGHT: begin
        emit = (r >= 2) && (c >= 2);
        ctr  = win[1][1];
        elem.sign_bits[0] = ctr > win[1][2];
        elem.sign_bits[1] = ctr > win[1][0];
        elem.sign_bits[2] = ctr > win[2][1];
        elem.sign_bits[3] = ctr > win[0][1];
        elem.sign_bits[4] = ctr > win[2][2];
        elem.sign_bits[5] = ctr > win[0][2];
        elem.sign_bits[6] = ctr > win[2][0];
        elem.sign_bits[7] = ctr > win[0][0];
      end
      MODE_HORIZ: begin
        emit = (c >= 1);
        elem.sign_bits[0] = win[2][1] > win[2][2];
      end
      default: begin
        emit = (r >= 1);
        elem.sign_bits[0] = win[1][2] > win[2][2];
      end
    endcase

    frame_end = (r == h - 1) && (c == w - 1);
    if (emit) begin
      elem.element_index = elem_cnt;
      elem.last          = frame_end;
      sign_q = {sign_q, elem};
      elem_cnt = elem_cnt + 1'b1;
    end

    // Advance raster position; wrap to a fresh frame after the final pixel
    if (frame_end) begin
      rewind_frame();
    end else if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endtask

  // Compare one delivered element against the oldest one owed
  task automatic check_element();
    nsd_result_t want;
    if (sign_q.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected element, expected none, actual index %0h bits %0h",
               $time, res_mon.element_index, res_mon.sign_bits);
    end else begin
      want = sign_q.pop_front();
      if (res_mon.sign_bits !== want.sign_bits)
        report("sign_bits", want.sign_bits, res_mon.sign_bits);
      if (res_mon.element_index !== want.element_index)
        report("element_index", want.element_index, res_mon.element_index);
      if (res_mon.last !== want.last)
        report("last", want.last, res_mon.last);
    end
  endtask

  // Watch the three channels; register writes land before pixels of the same edge
  always @(posedge clk) begin
    if (rst) begin
      side_reg = HASH_SIZE_RESET;
      mode_reg = MODE_EIGHT;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      end
      rewind_frame();
      sign_q.delete();
      fail_count = 0;
      pending   <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_HASH_SIZE) begin
          side_reg = cfg_mon.data;
          rewind_frame();
        end else if (cfg_mon.index == REG_MODE) begin
          mode_reg = cfg_mon.data[MODE_W-1:0];
          rewind_frame();
        end
      end
      if (res_mon.valid && res_mon.ready) check_element();
      if (pix_mon.valid && pix_mon.ready) predict_signs(pix_mon.pixel);
      pending <= sign_q.size();
    end
  end

endmodule

[tb/tb_neighbor_sign_descriptor.sv]
`timescale 1ns / 1ps

module tb_neighbor_sign_descriptor;
  import nsd_pkg::*;

  localparam int MAX_HS          = 64;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 6;
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int RANDOM_ITEMS    = 550;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst;
  int   fails;
  int   pending;
  int   pixels_sent = 0;
  int   idle_cycles = 0;
  bit   steady      = 1'b0;
  bit   squeeze_req = 1'b0;

  nsd_cfg_if    cfg_bus ();
  nsd_pixel_if  pix_bus ();
  nsd_result_if res_bus ();

  neighbor_sign_descriptor #(.MAX_HASH_SIZE(MAX_HS)) u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .pixels  (pix_bus),
    .results (res_bus)
  );

  nsd_scoreboard #(.MAX_HASH_SIZE(MAX_HS)) u_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_mon    (cfg_bus),
    .pix_mon    (pix_bus),
    .res_mon    (res_bus),
    .fail_count (fails),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  // Abort when no transaction moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int grid_pixels(input logic [HS_W-1:0] hs, input logic [MODE_W-1:0] md);
    int n;
    n = (hs == 0) ? 1 : ((hs > MAX_HS) ? MAX_HS : int'(hs));
    case (md)
      MODE_HORIZ: return (n + 1) * n;
      MODE_VERT:  return n * (n + 1);
      default:    return (n + 2) * (n + 2);
    endcase
  endfunction

  // Hold one register write until it is taken; valid stays up for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HS_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // Program side length and mode; mode data carries random upper bits
  task automatic set_config(input logic [HS_W-1:0] hs, input logic [MODE_W-1:0] md);
    logic [HS_W-1:0] mode_word;
    mode_word = HS_W'($urandom_range(0, 127));
    mode_word[MODE_W-1:0] = md;
    write_reg(REG_HASH_SIZE, hs);
    write_reg(REG_MODE, mode_word);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic offer_pixel(input logic [PIXEL_W-1:0] p);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.pixel <= p;
    do @(posedge clk); while (!pix_bus.ready);
    pixels_sent++;
  endtask

  // Drop valid, wait for every owed element, then let the pipeline empty
  task automatic settle();
    pix_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_grid9(input logic [PIXEL_W-1:0] vals [9]);
    foreach (vals[i]) offer_pixel(vals[i]);
    settle();
  endtask

  // Random backpressure on results, plus one long hold-off on request
  initial begin : result_sink
    bit squeezed;
    squeezed = 1'b0;
    res_bus.ready <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        res_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        res_bus.ready <= 1'b1;
        repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 12)) @(posedge clk);
        if ($urandom_range(0, 2) != 0) begin
          res_bus.ready <= 1'b0;
          repeat (($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(15, 50))
            @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic [PIXEL_W-1:0] grid [9];
    logic [HS_W-1:0]    hs;
    logic [MODE_W-1:0]  md;
    int                 base;
    int                 phase_no;
    int                 total;
    int                 split;
    int                 kind;
    int                 r;
    bit                 narrow;

    rst           <= 1'b1;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_HASH_SIZE;
    cfg_bus.data  <= '0;
    pix_bus.valid <= 1'b0;
    pix_bus.pixel <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Side length zero, eight neighbors: bright center over a black ring
    set_config('0, MODE_EIGHT);
    grid = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
    send_grid9(grid);

    // Smallest horizontal and vertical grids
    set_config(7'd1, MODE_HORIZ);
    offer_pixel(8'd255);
    offer_pixel(8'd0);
    settle();
    set_config(7'd1, MODE_VERT);
    offer_pixel(8'd0);
    offer_pixel(8'd255);
    settle();

    // Unused mode falls back to eight neighbors; mix of greater, less and equal
    set_config('0, MODE_UNUSED);
    grid = '{8'd100, 8'd200, 8'd128, 8'd127, 8'd128, 8'd129, 8'd128, 8'd0, 8'd255};
    send_grid9(grid);

    // Random phases, with the largest sizes in two truncated frames
    base     = pixels_sent;
    phase_no = 0;
    while (pixels_sent - base < RANDOM_ITEMS) begin
      kind = 0;
      if (phase_no == 2) begin
        hs          = 7'd64;
        md          = MODE_HORIZ;
        total       = 2 * (MAX_HS + 1) + 20;
        steady      = 1'b1;
        squeeze_req = 1'b1;
      end else if (phase_no == 5) begin
        hs    = 7'd127;
        md    = MODE_EIGHT;
        total = 2 * (MAX_HS + 2) + 5;
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0) hs = '0;
        else if (r == 1) hs = HS_W'($urandom_range(6, 9));
        else if (r == 2) hs = 7'd1;
        else hs = HS_W'($urandom_range(2, 5));
        md     = MODE_W'($urandom_range(0, 3));
        total  = $urandom_range(1, 3) * grid_pixels(hs, md);
        steady = ($urandom_range(0, 3) == 0);
        kind   = $urandom_range(0, 9);
        // Cut the stream short; the next register write restarts the frame
        if (kind >= 8) total = $urandom_range(1, total);
        // Keep the run near its item budget
        if (total > RANDOM_ITEMS - (pixels_sent - base))
          total = RANDOM_ITEMS - (pixels_sent - base);
      end
      narrow = ($urandom_range(0, 2) == 0);
      split  = (kind == 7 && total > 1) ? $urandom_range(1, total - 1) : 0;

      set_config(hs, md);
      for (int i = 0; i < total; i++) begin
        // Pause mid-frame and poke an unmapped index; the frame must carry on
        if (split != 0 && i == split) begin
          settle();
          write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                    HS_W'($urandom_range(0, 127)));
          cfg_bus.valid <= 1'b0;
        end
        offer_pixel(narrow ? PIXEL_W'($urandom_range(126, 129)) :
                             PIXEL_W'($urandom_range(0, 255)));
      end
      settle();
      steady      = 1'b0;
      squeeze_req = 1'b0;
      phase_no++;
    end

    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
